// ----- hdl/sepq_pkg.sv -----
// ----------------------------------------------------------------------------
// sepq_pkg
// Shared types, widths and codes of the sweep event priority queue.
// ----------------------------------------------------------------------------
package sepq_pkg;

  localparam int QUEUE_DEPTH  = 256;
  localparam int COORD_WIDTH  = 32;
  localparam int HANDLE_WIDTH = 16;
  localparam int CNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);
  localparam int PFX_LEVELS   = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_PEEK    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0]  key;
    logic [COORD_WIDTH-1:0]  site_x;
    logic [HANDLE_WIDTH-1:0] id;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic apply;
    logic report;
  } sepq_cmd_t;

  typedef struct packed {
    logic out_free;
  } sepq_stat_t;

endpackage

// ----- hdl/sepq_ctrl.sv -----
// ----------------------------------------------------------------------------
// sepq_ctrl
// Sequencer that steps one item through compare, update and report.
// ----------------------------------------------------------------------------
module sepq_ctrl
  import sepq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sepq_stat_t stat,
  output sepq_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_EVAL;
      S_EVAL:   state_next = S_APPLY;
      S_APPLY:  state_next = S_REPORT;
      S_REPORT: if (stat.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EVAL:   cmd.eval   = 1'b1;
      S_APPLY:  cmd.apply  = 1'b1;
      S_REPORT: cmd.report = stat.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/sepq_datapath.sv -----
// ----------------------------------------------------------------------------
// sepq_datapath
// Sorted cell array with per-cell compare, parallel shift and result register.
// ----------------------------------------------------------------------------
module sepq_datapath
  import sepq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  sepq_cmd_t               cmd,
  output sepq_stat_t              stat,
  input  logic [1:0]              in_op,
  input  logic [HANDLE_WIDTH-1:0] in_handle,
  input  logic [COORD_WIDTH-1:0]  in_site_y,
  input  logic [COORD_WIDTH-1:0]  in_site_x,
  input  logic [COORD_WIDTH-1:0]  in_offset,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [HANDLE_WIDTH-1:0] out_taken_handle,
  output logic [HANDLE_WIDTH-1:0] out_min_handle,
  output logic [COORD_WIDTH-1:0]  out_min_key,
  output logic [COORD_WIDTH-1:0]  out_min_site_x,
  output logic                    out_is_empty,
  output logic [CNT_WIDTH-1:0]    out_entry_count
);

  entry_t                  slot [QUEUE_DEPTH];
  logic [CNT_WIDTH-1:0]    count;

  op_t                     op_q;
  logic [HANDLE_WIDTH-1:0] handle_q;
  logic [COORD_WIDTH-1:0]  site_y_q;
  logic [COORD_WIDTH-1:0]  site_x_q;
  logic [COORD_WIDTH-1:0]  offset_q;

  entry_t                  new_entry;
  logic [QUEUE_DEPTH-1:0]  gt_q;
  logic [QUEUE_DEPTH-1:0]  rm_q;
  logic                    any_q;

  // Status and taken handle wait here until the result register is free.
  logic [1:0]              res_status;
  logic [HANDLE_WIDTH-1:0] res_taken;

  logic [COORD_WIDTH:0]    key_sum;
  logic [COORD_WIDTH-1:0]  key_sat;
  logic [QUEUE_DEPTH-1:0]  gt_c;
  logic [QUEUE_DEPTH-1:0]  match_c;
  logic [QUEUE_DEPTH-1:0]  pfx [PFX_LEVELS+1];
  logic                    do_ins;
  logic                    do_rm;

  assign stat.out_free = !out_valid || out_ready;

  // Saturating key sum.
  always_comb begin
    key_sum = {site_y_q[COORD_WIDTH-1], site_y_q} + {offset_q[COORD_WIDTH-1], offset_q};
    if (key_sum[COORD_WIDTH] != key_sum[COORD_WIDTH-1]) begin
      key_sat = {key_sum[COORD_WIDTH], {(COORD_WIDTH-1){!key_sum[COORD_WIDTH]}}};
    end else begin
      key_sat = key_sum[COORD_WIDTH-1:0];
    end
  end

  // Each cell compares itself against the new entry and the handle.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      logic vld;
      vld = CNT_WIDTH'(i) < count;
      gt_c[i] = vld && (($signed(key_sat) > $signed(slot[i].key)) ||
                ((key_sat == slot[i].key) && ($signed(site_x_q) > $signed(slot[i].site_x))));
      match_c[i] = vld && (slot[i].id == handle_q);
    end
  end

  // Parallel prefix OR marks every cell at or behind the removed one.
  always_comb begin
    pfx[0] = rm_q;
    for (int l = 0; l < PFX_LEVELS; l++) begin
      pfx[l+1] = pfx[l] | (pfx[l] << (1 << l));
    end
  end

  assign do_ins = (op_q == OP_INSERT) && (count < CNT_WIDTH'(QUEUE_DEPTH)) && !any_q;
  assign do_rm  = |rm_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= op_t'(in_op);
      handle_q <= in_handle;
      site_y_q <= in_site_y;
      site_x_q <= in_site_x;
      offset_q <= in_offset;
    end
    if (cmd.eval) begin
      new_entry <= '{key: key_sat, site_x: site_x_q, id: handle_q};
      gt_q      <= gt_c;
      any_q     <= |match_c;
      if (op_q == OP_DELETE) begin
        rm_q <= match_c;
      end else if (op_q == OP_EXTRACT && count != '0) begin
        rm_q <= QUEUE_DEPTH'(1);
      end else begin
        rm_q <= '0;
      end
    end
    if (cmd.apply) begin
      res_taken <= '0;
      unique case (op_q)
        OP_INSERT: res_status <= do_ins ? ST_OK : ST_FULL;
        OP_DELETE: res_status <= any_q ? ST_OK : ST_ABSENT;
        OP_EXTRACT: begin
          res_status <= (count == '0) ? ST_EMPTY : ST_OK;
          if (count != '0) res_taken <= slot[0].id;
        end
        OP_PEEK: res_status <= (count == '0) ? ST_EMPTY : ST_OK;
        default: res_status <= ST_OK;
      endcase
    end
    if (cmd.report) begin
      out_status       <= res_status;
      out_taken_handle <= res_taken;
      out_entry_count  <= count;
      out_is_empty     <= (count == '0);
      out_min_handle   <= (count == '0) ? '0 : slot[0].id;
      out_min_key      <= (count == '0) ? '0 : slot[0].key;
      out_min_site_x   <= (count == '0) ? '0 : slot[0].site_x;
    end
  end

  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.apply) begin
        if (do_ins && !gt_q[gi]) begin
          if (gi == 0) begin
            slot[gi] <= new_entry;
          end else if (gt_q[(gi == 0) ? 0 : gi-1]) begin
            slot[gi] <= new_entry;
          end else begin
            slot[gi] <= slot[(gi == 0) ? 0 : gi-1];
          end
        end else if (!do_ins && do_rm && pfx[PFX_LEVELS][gi] && (gi + 1 < QUEUE_DEPTH)) begin
          slot[gi] <= slot[(gi + 1 < QUEUE_DEPTH) ? gi+1 : gi];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.apply) begin
        if (do_ins) begin
          count <= count + CNT_WIDTH'(1);
        end else if (do_rm) begin
          count <= count - CNT_WIDTH'(1);
        end
      end
      if (cmd.report) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/sweep_event_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// sweep_event_priority_queue_top
// Bounded priority queue of sweep events held in a sorted cell array.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  s_axis   in         one operation item: op in tuser, handle and coordinates
//  m_axis   out        one result item per operation: status in tuser
//
// Every item steps through capture, a parallel compare in every cell
// (saturating key sum included), a parallel shift of the cell array, and
// loading the result register. The result register holds until it is taken;
// the next item is accepted meanwhile but waits in its report step for the
// slot. A synchronous reset empties the queue at once; the cells need no
// clearing pass.
// ----------------------------------------------------------------------------
module sweep_event_priority_queue_top
  import sepq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata from bit 0: handle[15:0], site_y[47:16], site_x[79:48], offset[111:80]
  input  logic [111:0] s_tdata,
  // tuser: op[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata from bit 0: taken_handle[15:0], min_handle[31:16], min_key[63:32],
  // min_site_x[95:64], is_empty[96], entry_count[105:97], zero fill above
  output logic [111:0] m_tdata,
  // tuser: status[1:0]
  output logic [1:0]   m_tuser
);

  sepq_cmd_t               cmd;
  sepq_stat_t              stat;
  logic [HANDLE_WIDTH-1:0] taken_handle;
  logic [HANDLE_WIDTH-1:0] min_handle;
  logic [COORD_WIDTH-1:0]  min_key;
  logic [COORD_WIDTH-1:0]  min_site_x;
  logic                    is_empty;
  logic [CNT_WIDTH-1:0]    entry_count;

  // The sequencer walks each item through its steps.
  sepq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath owns the cells, the count and the result register.
  sepq_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (s_tuser),
    .in_handle        (s_tdata[15:0]),
    .in_site_y        (s_tdata[47:16]),
    .in_site_x        (s_tdata[79:48]),
    .in_offset        (s_tdata[111:80]),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_status       (m_tuser),
    .out_taken_handle (taken_handle),
    .out_min_handle   (min_handle),
    .out_min_key      (min_key),
    .out_min_site_x   (min_site_x),
    .out_is_empty     (is_empty),
    .out_entry_count  (entry_count)
  );

  assign m_tdata = {6'd0, entry_count, is_empty, min_site_x, min_key, min_handle, taken_handle};

`ifndef SYNTHESIS
  // The queue never reports more entries than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (entry_count <= CNT_WIDTH'(QUEUE_DEPTH)))
    else $error("entry count beyond depth");

  // The empty flag agrees with the count.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");

  // Only a successful operation reports a taken handle.
  a_taken_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (taken_handle == '0))
    else $error("taken handle on failed operation");

  // An accepted item blocks intake while it is worked on.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted during work");
`endif

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives operation items into the sweep event priority queue, keeps a sorted
// shadow queue to predict each result item, and compares every result item
// field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import sepq_pkg::*;

  typedef struct packed {
    logic [1:0]   op;
    logic [111:0] data;
  } op_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] taken;
    logic [15:0] min_handle;
    logic [31:0] min_key;
    logic [31:0] min_x;
    logic        empty;
    logic [8:0]  count;
  } report_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic [1:0]   m_tuser;

  sweep_event_priority_queue_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the sorted cell array.
  logic signed [31:0] sh_key [$];
  logic signed [31:0] sh_x   [$];
  logic [15:0]        sh_id  [$];

  op_item_t pending_ops [$];
  report_t  expected_reports [$];
  int       mismatches = 0;
  int       long_hold = 0;
  bit       held_long = 0;
  int       sent = 0;

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s > 33'sd2147483647) return 32'sh7fffffff;
    if (s < -33'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic int locate(logic [15:0] h);
    foreach (sh_id[i]) if (sh_id[i] == h) return i;
    return -1;
  endfunction

  // Applies one operation to the shadow queue and returns its report.
  function automatic report_t apply_op(op_item_t it);
    report_t r;
    logic [15:0] h;
    logic signed [31:0] sy, sx, off, k;
    int p;
    h = it.data[15:0];
    sy = it.data[47:16];
    sx = it.data[79:48];
    off = it.data[111:80];
    r = '0;
    r.status = ST_OK;
    case (op_t'(it.op))
      OP_INSERT: begin
        if (sh_id.size() >= QUEUE_DEPTH || locate(h) >= 0) begin
          r.status = ST_FULL;
        end else begin
          k = sat_sum(sy, off);
          p = 0;
          while (p < sh_id.size() &&
                 (k > sh_key[p] || (k == sh_key[p] && sx > sh_x[p]))) p++;
          sh_key.insert(p, k);
          sh_x.insert(p, sx);
          sh_id.insert(p, h);
        end
      end
      OP_DELETE: begin
        p = locate(h);
        if (p < 0) begin
          r.status = ST_ABSENT;
        end else begin
          sh_key.delete(p);
          sh_x.delete(p);
          sh_id.delete(p);
        end
      end
      OP_EXTRACT: begin
        if (sh_id.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.taken = sh_id[0];
          sh_key.delete(0);
          sh_x.delete(0);
          sh_id.delete(0);
        end
      end
      default: if (sh_id.size() == 0) r.status = ST_EMPTY;
    endcase
    if (sh_id.size() > 0) begin
      r.min_handle = sh_id[0];
      r.min_key = sh_key[0];
      r.min_x = sh_x[0];
    end else begin
      r.empty = 1'b1;
    end
    r.count = 9'(sh_id.size());
    return r;
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'h7fffffff - $urandom_range(0, 3);
      2: return 32'h80000000 + $urandom_range(0, 3);
      default: return $urandom_range(0, 7) << 16;
    endcase
  endfunction

  task automatic push_op(op_t op, logic [15:0] h, logic [31:0] y, logic [31:0] x,
                         logic [31:0] off);
    op_item_t it;
    it.op = op;
    it.data = {off, x, y, h};
    pending_ops.push_back(it);
  endtask

  // Driver: offers items with random gaps, most short, a few long.
  int gap = 0;
  op_item_t cur;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_reports.push_back(apply_op(cur));
        sent <= sent + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (gap > 0) begin
          gap <= gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          cur = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur.op;
          s_tdata <= cur.data;
          gap <= ($urandom_range(0, 9) < 6) ? 0 :
                 ($urandom_range(0, 19) == 0 ? $urandom_range(10, 40)
                                             : $urandom_range(1, 3));
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results; the receiver stalls at random, once for long.
  report_t got, want;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[63:32],
               m_tdata[95:64], m_tdata[96], m_tdata[105:97]};
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h", got);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want || m_tdata[111:106] !== '0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: status %0d/%0d taken %h/%h min %h/%h",
                       want.status, got.status, want.taken, got.taken,
                       want.min_handle, got.min_handle);
              $display("  key %h/%h x %h/%h empty %b/%b count %0d/%0d",
                       want.min_key, got.min_key, want.min_x, got.min_x,
                       want.empty, got.empty, want.count, got.count);
            end
          end
        end
      end
      if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        m_tready <= 1'b0;
      end else if (sent >= 40 && !held_long) begin
        held_long <= 1'b1;
        long_hold <= 200;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        long_hold <= $urandom_range(8, 30);
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  initial begin
    int n, mode;
    logic [15:0] h;
    // Directed part: empty cases, extremes, saturation, ties, duplicates.
    push_op(OP_PEEK, 16'h0, 0, 0, 0);
    push_op(OP_EXTRACT, 16'h0, 0, 0, 0);
    push_op(OP_DELETE, 16'hffff, 0, 0, 0);
    push_op(OP_INSERT, 16'hffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    push_op(OP_INSERT, 16'h0000, 32'h80000000, 32'h80000000, 32'h80000000);
    push_op(OP_INSERT, 16'h0001, 32'h00010000, 32'h0, 32'h00010000);
    push_op(OP_INSERT, 16'h0002, 32'h00020000, 32'h0, 32'h0);
    push_op(OP_INSERT, 16'h0003, 32'h00020000, 32'hffff0000, 32'h0);
    push_op(OP_INSERT, 16'h0004, 32'h00020000, 32'h0, 32'h0);
    push_op(OP_INSERT, 16'h0002, 32'h0, 32'h0, 32'h0);
    push_op(OP_PEEK, 16'h0, 0, 0, 0);
    push_op(OP_DELETE, 16'h0003, 0, 0, 0);
    push_op(OP_DELETE, 16'h0003, 0, 0, 0);
    push_op(OP_INSERT, 16'haaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
    push_op(OP_INSERT, 16'h5555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
    for (int i = 0; i < 8; i++) push_op(OP_EXTRACT, 16'h0, 0, 0, 0);
    // Fill to full, overflow twice, then drain part.
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      push_op(OP_INSERT, 16'(16'h1000 + i), $urandom_range(0, 7) << 16,
              $urandom_range(0, 3) << 16, $urandom());
    push_op(OP_INSERT, 16'h0777, 0, 0, 0);
    push_op(OP_PEEK, 16'h0, 0, 0, 0);
    for (int i = 0; i < 20; i++)
      push_op(OP_DELETE, 16'(16'h1000 + $urandom_range(0, QUEUE_DEPTH)), 0, 0, 0);
    for (int i = 0; i < 100; i++) push_op(OP_EXTRACT, 16'h0, 0, 0, 0);
    // Random part: handles drawn from a small pool to hit duplicates and deletes.
    for (int i = 0; i < 150; i++) begin
      n = $urandom_range(0, 9);
      mode = $urandom_range(0, 9) < 6 ? 3 : $urandom_range(0, 2);
      h = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 40));
      if (n < 5) push_op(OP_INSERT, h, rand_coord(mode), rand_coord(mode), rand_coord(mode));
      else if (n < 7) push_op(OP_DELETE, h, $urandom(), $urandom(), $urandom());
      else if (n < 9) push_op(OP_EXTRACT, h, $urandom(), $urandom(), $urandom());
      else push_op(OP_PEEK, h, $urandom(), $urandom(), $urandom());
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_ops.size() != 0 || s_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule
